[rtl/windowed_cubic_sample_interpolator_defines.svh]
// Assertion helpers shared by the interpolator RTL
`ifndef WINDOWED_CUBIC_SAMPLE_INTERPOLATOR_DEFINES_SVH
`define WINDOWED_CUBIC_SAMPLE_INTERPOLATOR_DEFINES_SVH

// same-cycle implication
`define WCSI_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define WCSI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/wcsi_pkg.sv]
package wcsi_pkg;

	localparam int RING_DEPTH = 16;
	localparam int IDX_W      = $clog2(RING_DEPTH);
	localparam int CNT_W      = $clog2(RING_DEPTH + 1);
	localparam int MU_W       = 17;
	localparam int COEF_W     = 19;
	localparam int PROD_W     = 37;
	localparam int ACC_W      = 40;

	typedef enum logic [1:0] {
		REQ_ADD   = 2'd0,
		REQ_QUERY = 2'd1,
		REQ_CLEAR = 2'd2
	} req_t;

	typedef enum logic [2:0] {
		QS_EMPTY  = 3'd0,
		QS_BEFORE = 3'd1,
		QS_INTERP = 3'd2,
		QS_AFTER  = 3'd3,
		QS_EQUAL  = 3'd4
	} status_t;

	typedef struct packed {
		logic le;
		logic lt;
	} lane_flags_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] a0;
		logic signed [COEF_W-1:0] a1;
		logic signed [COEF_W-1:0] a2;
	} coef_t;

	function automatic logic [IDX_W-1:0] slot_add(input logic [IDX_W-1:0] a,
			input logic [IDX_W-1:0] b);
		logic [IDX_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= (IDX_W+1)'(RING_DEPTH))
			s = s - (IDX_W+1)'(RING_DEPTH);
		return s[IDX_W-1:0];
	endfunction

	function automatic logic signed [15:0] avg16(input logic signed [15:0] a,
			input logic signed [15:0] b);
		logic signed [16:0] s;
		s = 17'(a) + 17'(b);
		return s[16:1];
	endfunction

	function automatic coef_t make_coef(input logic signed [15:0] p0,
			input logic signed [15:0] p1, input logic signed [15:0] p2,
			input logic signed [15:0] p3);
		coef_t c;
		c.a0 = COEF_W'(p3) - COEF_W'(p2) - COEF_W'(p0) + COEF_W'(p1);
		c.a1 = COEF_W'(p0) - COEF_W'(p1) - c.a0;
		c.a2 = COEF_W'(p2) - COEF_W'(p0);
		return c;
	endfunction

	function automatic logic signed [15:0] finish(input logic signed [ACC_W-1:0] acc,
			input logic signed [15:0] p1);
		logic signed [ACC_W-1:0] s;
		s = ((acc + ACC_W'(32768)) >>> 16) + ACC_W'(p1);
		if (s > ACC_W'(32767))
			return 16'sh7fff;
		else if (s < -ACC_W'(32768))
			return 16'sh8000;
		return s[15:0];
	endfunction

endpackage

[rtl/wcsi_lane.sv]
module wcsi_lane import wcsi_pkg::*; (
	input  logic        clk,
	input  logic [31:0] query_time,
	input  logic [31:0] slot_time,
	output lane_flags_t flags_s1
);

	always_ff @(posedge clk) begin
		flags_s1.le <= query_time <= slot_time;
		flags_s1.lt <= query_time < slot_time;
	end

endmodule

[rtl/wcsi_div.sv]
module wcsi_div import wcsi_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [31:0]     num,
	input  logic [31:0]     den,
	output logic            done,
	output logic [MU_W-1:0] quo
);

	localparam int STEP_W = $clog2(MU_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [32:0]       rem_q;
	logic [MU_W-1:0]   quo_q;
	logic [31:0]       den_q;
	logic              ge;
	logic [32:0]       rem_nx;

	assign ge     = rem_q >= {1'b0, den_q};
	assign rem_nx = ge ? rem_q - {1'b0, den_q} : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(MU_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, num};
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= {rem_nx[31:0], 1'b0};
			quo_q <= {quo_q[MU_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

[rtl/windowed_cubic_sample_interpolator.sv]
// Windowed four-point cubic interpolator over timestamped (x, y) samples.
// Input channel s_*: one transaction per request; s_tuser is the request kind
// (add, query, clear), s_tdata carries time and the sample value.
// Output channel m_*: one transaction per query, with the interpolated value
// and a status code; adds, clears and unknown kinds produce nothing.
// cfg_we/cfg_wdata write the age window; write it only while the block is idle.
// Sixteen compare lanes test the query time against every stored time at
// once; the merge picks the bracketing pair, four single-port reads fetch the
// neighbors, a 17-step serial divider forms mu, and one shared multiplier runs
// eight products in turn.
// A query runs the lane, merge, read, check, divide and multiply states, then
// registers its result (empty ring: merge goes straight to it; outside or
// equal-time cases skip divide and multiply); the next request is taken in the
// cycle m_tvalid rises. An add evicts samples outside the window, then appends; a clear acts on acceptance.
// One request is in work at a time.
// The result waits in an output register; a stalled receiver blocks only the
// next query from finishing, adds and clears are still taken.
// Reset empties the ring, drops any pending result and sets the window to 1.0.
module windowed_cubic_sample_interpolator import wcsi_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // sample_time[31:0], sample_x[47:32], sample_y[63:48]
	input  logic [1:0]  s_tuser,   // req_type[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // value_x[15:0], value_y[31:16]
	output logic [2:0]  m_tuser,   // query_status[2:0]
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);

`include "windowed_cubic_sample_interpolator_defines.svh"

	typedef enum logic [10:0] {
		ST_IDLE   = 11'b000_0000_0001,
		ST_NEWEST = 11'b000_0000_0010,
		ST_EVICT  = 11'b000_0000_0100,
		ST_APPEND = 11'b000_0000_1000,
		ST_LANE   = 11'b000_0001_0000,
		ST_MERGE  = 11'b000_0010_0000,
		ST_READ   = 11'b000_0100_0000,
		ST_CHECK  = 11'b000_1000_0000,
		ST_DIV    = 11'b001_0000_0000,
		ST_MUL    = 11'b010_0000_0000,
		ST_DONE   = 11'b100_0000_0000
	} state_t;

	state_t state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] oldest_q;
	logic [31:0]      win_q;

	logic [31:0]        time_q [RING_DEPTH];
	logic signed [15:0] xs_q   [RING_DEPTH];
	logic signed [15:0] ys_q   [RING_DEPTH];

	logic [31:0]        t_q;
	logic signed [15:0] in_x_q;
	logic signed [15:0] in_y_q;
	logic [31:0]        limit_q;
	logic [IDX_W-1:0]   idx_q [4];
	logic [1:0]         rd_cnt_q;
	status_t            kind_q;
	logic signed [15:0] px_q [4];
	logic signed [15:0] py_q [4];
	logic [31:0]        t1_q;
	logic [31:0]        t2_q;
	logic [MU_W-1:0]    mu_q;
	logic [MU_W-1:0]    mu2_q;
	logic [MU_W-1:0]    mu3_q;
	logic [3:0]         mstep_q;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [ACC_W-1:0]  acc_x_q;
	logic signed [ACC_W-1:0]  acc_y_q;
	logic signed [15:0] res_x_q;
	logic signed [15:0] res_y_q;
	status_t            res_st_q;
	logic               m_valid_q;
	logic [31:0]        m_data_q;
	status_t            m_st_q;

	logic               s_acc;
	logic [IDX_W-1:0]   rd_log;
	logic [IDX_W-1:0]   rd_slot;
	logic [31:0]        rd_time;
	logic signed [15:0] rd_x;
	logic signed [15:0] rd_y;
	logic [IDX_W-1:0]   newest_log;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_slot;
	logic [31:0]        wr_time;
	logic signed [15:0] wr_x;
	logic signed [15:0] wr_y;

	lane_flags_t        lane_s1 [RING_DEPTH];
	logic [RING_DEPTH-1:0] rot_le;
	logic [RING_DEPTH-1:0] rot_lt;
	logic               hit;
	logic [IDX_W-1:0]   hit_idx;

	logic               div_start;
	logic               div_done;
	logic [MU_W-1:0]    div_quo;

	coef_t              cx;
	coef_t              cy;
	logic [2:0]         op;
	logic signed [COEF_W-1:0] mul_a;
	logic signed [MU_W:0]     mul_b;
	logic               out_free;

	assign s_acc      = s_tvalid && s_tready;
	assign s_tready   = state_q == ST_IDLE;
	assign newest_log = IDX_W'(cnt_q - 1'b1);
	assign out_free   = !m_valid_q || m_tready;

	always_comb begin
		case (state_q)
			ST_NEWEST, ST_APPEND: rd_log = newest_log;
			ST_READ:              rd_log = idx_q[rd_cnt_q];
			default:              rd_log = '0;
		endcase
	end

	assign rd_slot = slot_add(oldest_q, rd_log);
	assign rd_time = time_q[rd_slot];
	assign rd_x    = xs_q[rd_slot];
	assign rd_y    = ys_q[rd_slot];

	// compare lanes, one per physical slot
	for (genvar g = 0; g < RING_DEPTH; g++) begin : g_lane
		wcsi_lane u_lane (
			.clk        (clk),
			.query_time (t_q),
			.slot_time  (time_q[g]),
			.flags_s1   (lane_s1[g])
		);
	end

	// merge: rotate to logical order, find first bracketing entry
	always_comb begin
		hit     = 1'b0;
		hit_idx = '0;
		for (int k = 0; k < RING_DEPTH; k++) begin
			rot_le[k] = lane_s1[slot_add(oldest_q, IDX_W'(k))].le;
			rot_lt[k] = lane_s1[slot_add(oldest_q, IDX_W'(k))].lt;
		end
		for (int k = RING_DEPTH - 1; k >= 1; k--) begin
			if (rot_le[k] && (CNT_W'(k) < cnt_q)) begin
				hit     = 1'b1;
				hit_idx = IDX_W'(k);
			end
		end
	end

	// append / average writes
	always_comb begin
		wr_en   = 1'b0;
		wr_slot = rd_slot;
		wr_time = t_q;
		wr_x    = in_x_q;
		wr_y    = in_y_q;
		if (state_q == ST_APPEND) begin
			wr_en = 1'b1;
			if (cnt_q != '0 && rd_time == t_q) begin
				wr_x = avg16(rd_x, in_x_q);
				wr_y = avg16(rd_y, in_y_q);
			end else if (cnt_q == CNT_W'(RING_DEPTH)) begin
				wr_slot = oldest_q;
			end else begin
				wr_slot = slot_add(oldest_q, IDX_W'(cnt_q));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			time_q[wr_slot] <= wr_time;
			xs_q[wr_slot]   <= wr_x;
			ys_q[wr_slot]   <= wr_y;
		end
	end

	assign div_start = state_q == ST_CHECK && kind_q == QS_INTERP && t1_q != t2_q;

	wcsi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (t_q - t1_q),
		.den    (t2_q - t1_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign cx = make_coef(px_q[0], px_q[1], px_q[2], px_q[3]);
	assign cy = make_coef(py_q[0], py_q[1], py_q[2], py_q[3]);
	assign op = mstep_q[3:1];

	always_comb begin
		case (op)
			3'd0:    begin mul_a = COEF_W'(mu_q); mul_b = {1'b0, mu_q};  end
			3'd1:    begin mul_a = COEF_W'(mu_q); mul_b = {1'b0, mu2_q}; end
			3'd2:    begin mul_a = cx.a0;         mul_b = {1'b0, mu3_q}; end
			3'd3:    begin mul_a = cx.a1;         mul_b = {1'b0, mu2_q}; end
			3'd4:    begin mul_a = cx.a2;         mul_b = {1'b0, mu_q};  end
			3'd5:    begin mul_a = cy.a0;         mul_b = {1'b0, mu3_q}; end
			3'd6:    begin mul_a = cy.a1;         mul_b = {1'b0, mu2_q}; end
			default: begin mul_a = cy.a2;         mul_b = {1'b0, mu_q};  end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_MUL && !mstep_q[0])
			prod_s1 <= PROD_W'(mul_a) * PROD_W'(mul_b);
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			oldest_q  <= '0;
			win_q     <= 32'h0001_0000;
			m_valid_q <= 1'b0;
			rd_cnt_q  <= '0;
			mstep_q   <= '0;
		end else begin
			if (cfg_we)
				win_q <= cfg_wdata;
			if (m_valid_q && m_tready && state_q != ST_DONE)
				m_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						case (s_tuser)
							REQ_ADD:   state_q <= ST_NEWEST;
							REQ_QUERY: state_q <= ST_LANE;
							REQ_CLEAR: begin
								cnt_q    <= '0;
								oldest_q <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_NEWEST: begin
					if (cnt_q != '0 && rd_time >= win_q)
						state_q <= ST_EVICT;
					else
						state_q <= ST_APPEND;
				end
				ST_EVICT: begin
					if (cnt_q != '0 && rd_time < limit_q) begin
						oldest_q <= slot_add(oldest_q, IDX_W'(1));
						cnt_q    <= cnt_q - 1'b1;
					end else begin
						state_q <= ST_APPEND;
					end
				end
				ST_APPEND: begin
					state_q <= ST_IDLE;
					if (!(cnt_q != '0 && rd_time == t_q)) begin
						if (cnt_q == CNT_W'(RING_DEPTH))
							oldest_q <= slot_add(oldest_q, IDX_W'(1));
						else
							cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_LANE: state_q <= ST_MERGE;
				ST_MERGE: begin
					rd_cnt_q <= '0;
					state_q  <= (cnt_q == '0) ? ST_DONE : ST_READ;
				end
				ST_READ: begin
					rd_cnt_q <= rd_cnt_q + 1'b1;
					if (rd_cnt_q == 2'd3)
						state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					state_q <= div_start ? ST_DIV : ST_DONE;
				end
				ST_DIV: begin
					mstep_q <= '0;
					if (div_done)
						state_q <= ST_MUL;
				end
				ST_MUL: begin
					mstep_q <= mstep_q + 1'b1;
					if (mstep_q == 4'd15)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (s_acc) begin
			t_q    <= s_tdata[31:0];
			in_x_q <= s_tdata[47:32];
			in_y_q <= s_tdata[63:48];
		end
		if (state_q == ST_NEWEST)
			limit_q <= rd_time - win_q;
		if (state_q == ST_MERGE) begin
			res_x_q  <= '0;
			res_y_q  <= '0;
			res_st_q <= QS_EMPTY;
			if (rot_lt[0]) begin
				kind_q <= QS_BEFORE;
				for (int i = 0; i < 4; i++)
					idx_q[i] <= '0;
			end else if (!hit) begin
				kind_q <= QS_AFTER;
				for (int i = 0; i < 4; i++)
					idx_q[i] <= newest_log;
			end else begin
				kind_q   <= QS_INTERP;
				idx_q[1] <= hit_idx - 1'b1;
				idx_q[2] <= hit_idx;
				idx_q[0] <= (hit_idx > IDX_W'(1)) ? hit_idx - IDX_W'(2) : hit_idx - 1'b1;
				idx_q[3] <= (CNT_W'(hit_idx) < cnt_q - 1'b1) ? hit_idx + 1'b1 : hit_idx;
			end
		end
		if (state_q == ST_READ) begin
			px_q[rd_cnt_q] <= rd_x;
			py_q[rd_cnt_q] <= rd_y;
			if (rd_cnt_q == 2'd1)
				t1_q <= rd_time;
			if (rd_cnt_q == 2'd2)
				t2_q <= rd_time;
		end
		if (state_q == ST_CHECK) begin
			if (kind_q != QS_INTERP) begin
				res_x_q  <= px_q[1];
				res_y_q  <= py_q[1];
				res_st_q <= kind_q;
			end else if (t1_q == t2_q) begin
				res_x_q  <= avg16(px_q[1], px_q[2]);
				res_y_q  <= avg16(py_q[1], py_q[2]);
				res_st_q <= QS_EQUAL;
			end
		end
		if (state_q == ST_DIV && div_done)
			mu_q <= div_quo;
		if (state_q == ST_MUL && mstep_q[0]) begin
			case (op)
				3'd0:    mu2_q   <= prod_s1[32:16];
				3'd1:    mu3_q   <= prod_s1[32:16];
				3'd2:    acc_x_q <= ACC_W'(prod_s1);
				3'd3,
				3'd4:    acc_x_q <= acc_x_q + ACC_W'(prod_s1);
				3'd5:    acc_y_q <= ACC_W'(prod_s1);
				default: acc_y_q <= acc_y_q + ACC_W'(prod_s1);
			endcase
		end
		if (state_q == ST_MUL && mstep_q == 4'd15) begin
			res_x_q  <= finish(acc_x_q, px_q[1]);
			res_y_q  <= finish(acc_y_q + ACC_W'(prod_s1), py_q[1]);
			res_st_q <= QS_INTERP;
		end
		if (state_q == ST_DONE && out_free) begin
			m_data_q <= {res_y_q, res_x_q};
			m_st_q   <= res_st_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_st_q;

	`WCSI_ASSERT_NOW(a_cnt_range, 1'b1, cnt_q <= CNT_W'(RING_DEPTH),
		"sample count beyond ring depth")
	`WCSI_ASSERT_NOW(a_div_done_state, div_done, state_q == ST_DIV,
		"divider finished outside the divide step")
	`WCSI_ASSERT_NOW(a_result_source, $rose(m_tvalid), $past(state_q == ST_DONE),
		"result raised without a finished query")
	`WCSI_ASSERT_NEXT(a_add_no_result, s_acc && s_tuser == REQ_ADD, state_q == ST_NEWEST,
		"add request did not start the newest-time lookup")

endmodule
